@@ rtl/tet_pkg.sv @@
// Shared constants, types and the microcode program of the timeout event table.
package tet_pkg;

    localparam int SLOT_COUNT_DEF = 32;
    localparam int MAX_SLOTS      = 32;

    localparam int KIND_W    = 2;
    localparam int DELAY_W   = 24;
    localparam int HANDLER_W = 8;
    localparam int TAG_W     = 16;
    localparam int SLOT_W    = 5;
    localparam int COUNT_W   = 19;
    localparam int PROD_W    = 32;
    localparam int ENTRY_W   = COUNT_W + HANDLER_W + TAG_W;

    localparam logic [PROD_W-1:0] TICKS_NUM   = PROD_W'(182);
    localparam logic [PROD_W-1:0] TICKS_RECIP = 32'hD1B7_1759;
    localparam int                RECIP_SHIFT = 45;

    localparam logic [KIND_W-1:0] KIND_TICK   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POST   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CANCEL = 2'd2;

    localparam logic [KIND_W-1:0] RES_GRANTED = 2'd0;
    localparam logic [KIND_W-1:0] RES_FULL    = 2'd1;
    localparam logic [KIND_W-1:0] RES_FIRED   = 2'd2;

    typedef logic [2:0] upc_t;

    localparam upc_t PC_IDLE       = 3'd0;
    localparam upc_t PC_TICK_RD    = 3'd1;
    localparam upc_t PC_TICK_SLOT  = 3'd2;
    localparam upc_t PC_TICK_FLUSH = 3'd3;
    localparam upc_t PC_POST_MUL1  = 3'd4;
    localparam upc_t PC_POST_MUL2  = 3'd5;
    localparam upc_t PC_POST_SRCH  = 3'd6;
    localparam upc_t PC_POST_GRANT = 3'd7;

    typedef enum logic [2:0] {
        ACT_DISPATCH,
        ACT_READ,
        ACT_TICK_SLOT,
        ACT_FLUSH,
        ACT_MUL1,
        ACT_MUL2,
        ACT_SEARCH,
        ACT_GRANT
    } act_t;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_DISPATCH,
        COND_MORE,
        COND_SEARCH
    } cond_t;

    typedef struct packed {
        act_t  act;
        cond_t cond;
        upc_t  target;
    } ucode_t;

    // When the condition holds the sequencer jumps to target, else it steps on by one.
    function automatic ucode_t ucode_rom(input upc_t pc);
        ucode_t w;
        case (pc)
            PC_IDLE:       w = '{ACT_DISPATCH,  COND_DISPATCH, PC_IDLE};
            PC_TICK_RD:    w = '{ACT_READ,      COND_NEVER,    PC_IDLE};
            PC_TICK_SLOT:  w = '{ACT_TICK_SLOT, COND_MORE,     PC_TICK_SLOT};
            PC_TICK_FLUSH: w = '{ACT_FLUSH,     COND_ALWAYS,   PC_IDLE};
            PC_POST_MUL1:  w = '{ACT_MUL1,      COND_NEVER,    PC_IDLE};
            PC_POST_MUL2:  w = '{ACT_MUL2,      COND_NEVER,    PC_IDLE};
            PC_POST_SRCH:  w = '{ACT_SEARCH,    COND_SEARCH,   PC_POST_SRCH};
            PC_POST_GRANT: w = '{ACT_GRANT,     COND_ALWAYS,   PC_IDLE};
            default:       w = '{ACT_DISPATCH,  COND_DISPATCH, PC_IDLE};
        endcase
        return w;
    endfunction

endpackage

@@ rtl/timeout_event_table_top.sv @@
// Timeout event table: microcoded sequencer over a slot memory with a valid bit per slot.
// A tick walks the slots one per cycle while a stalled output does not hold the walk.
// A post runs two multiply steps, a lowest-free-slot walk and the grant; a stalled output holds the grant.
// A cancel, or an unused kind, keeps the sequencer idle; the next word is accepted in the following cycle.
// The slot walk over the one read port of the slot memory sets the rate; words arrive one at a time.
// Reset clears all valid bits at once, so the table is usable right after reset with no clearing pass.
module timeout_event_table_top
    import tet_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [KIND_W-1:0]    kind,
    input  logic [DELAY_W-1:0]   delay_ms,
    input  logic [HANDLER_W-1:0] handler_id,
    input  logic [TAG_W-1:0]     callback_tag,
    input  logic [SLOT_W-1:0]    slot_index,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [KIND_W-1:0]    result_kind,
    output logic [SLOT_W-1:0]    slot_number,
    output logic [HANDLER_W-1:0] fired_handler,
    output logic [TAG_W-1:0]     fired_tag,
    output logic                 last_of_run
);

    localparam int USED = (SLOT_COUNT < MAX_SLOTS) ? SLOT_COUNT : MAX_SLOTS;
    localparam int IW   = (USED > 1) ? $clog2(USED) : 1;

    logic [ENTRY_W-1:0] mem [0:USED-1];

    upc_t                 pc_reg,          pc_next;
    logic [IW-1:0]        idx_reg,         idx_next;
    logic [USED-1:0]      valid_reg,       valid_next;
    logic                 pend_valid_reg,  pend_valid_next;
    logic [IW-1:0]        pend_slot_reg,   pend_slot_next;
    logic [HANDLER_W-1:0] pend_handler_reg, pend_handler_next;
    logic [TAG_W-1:0]     pend_tag_reg,    pend_tag_next;
    logic [DELAY_W-1:0]   delay_reg,       delay_next;
    logic [HANDLER_W-1:0] handler_reg,     handler_next;
    logic [TAG_W-1:0]     tag_reg,         tag_next;
    logic [PROD_W-1:0]    prod_reg,        prod_next;
    logic [COUNT_W-1:0]   quot_reg,        quot_next;
    logic                 out_valid_reg,   out_valid_next;
    logic [KIND_W-1:0]    res_kind_reg,    res_kind_next;
    logic [SLOT_W-1:0]    res_slot_reg,    res_slot_next;
    logic [HANDLER_W-1:0] res_handler_reg, res_handler_next;
    logic [TAG_W-1:0]     res_tag_reg,     res_tag_next;
    logic                 res_last_reg,    res_last_next;
    logic [ENTRY_W-1:0]   rd_data_reg;

    ucode_t               uword;
    logic                 in_accept;
    logic                 out_free;
    logic                 idx_last;
    logic                 slot_on;
    logic                 fire;
    logic                 needs_out;
    logic                 hold;
    logic                 cond_true;
    logic [COUNT_W-1:0]   rd_count;
    logic [HANDLER_W-1:0] rd_handler;
    logic [TAG_W-1:0]     rd_tag;
    logic [2*PROD_W-1:0]  recip_prod;
    logic [IW-1:0]        rd_addr;
    logic                 mem_we;
    logic [ENTRY_W-1:0]   mem_wdata;

    assign uword      = ucode_rom(pc_reg);
    assign in_stall   = (pc_reg != PC_IDLE);
    assign in_accept  = in_valid && !in_stall;
    assign out_free   = !out_valid_reg || !out_stall;
    assign idx_last   = (idx_reg == IW'(USED - 1));
    assign slot_on    = valid_reg[idx_reg];
    assign rd_count   = rd_data_reg[ENTRY_W-1 -: COUNT_W];
    assign rd_handler = rd_data_reg[TAG_W +: HANDLER_W];
    assign rd_tag     = rd_data_reg[TAG_W-1:0];
    assign fire       = slot_on && (rd_count == '0);
    assign recip_prod = (2*PROD_W)'(prod_reg) * (2*PROD_W)'(TICKS_RECIP);

    assign out_valid     = out_valid_reg;
    assign result_kind   = res_kind_reg;
    assign slot_number   = res_slot_reg;
    assign fired_handler = res_handler_reg;
    assign fired_tag     = res_tag_reg;
    assign last_of_run   = res_last_reg;

    always_comb
    begin
        case (uword.act)
            ACT_TICK_SLOT: needs_out = fire && pend_valid_reg;
            ACT_FLUSH:     needs_out = pend_valid_reg;
            ACT_GRANT:     needs_out = 1'b1;
            default:       needs_out = 1'b0;
        endcase
        hold = needs_out && !out_free;

        case (uword.cond)
            COND_ALWAYS: cond_true = 1'b1;
            COND_MORE:   cond_true = !idx_last;
            COND_SEARCH: cond_true = slot_on && !idx_last;
            default:     cond_true = 1'b0;
        endcase

        if ((uword.act == ACT_TICK_SLOT) && !hold && !idx_last)
        begin
            rd_addr = IW'(idx_reg + 1'b1);
        end
        else
        begin
            rd_addr = idx_reg;
        end
    end

    always_comb
    begin
        pc_next           = pc_reg;
        idx_next          = idx_reg;
        valid_next        = valid_reg;
        pend_valid_next   = pend_valid_reg;
        pend_slot_next    = pend_slot_reg;
        pend_handler_next = pend_handler_reg;
        pend_tag_next     = pend_tag_reg;
        delay_next        = delay_reg;
        handler_next      = handler_reg;
        tag_next          = tag_reg;
        prod_next         = prod_reg;
        quot_next         = quot_reg;
        out_valid_next    = out_valid_reg && out_stall;
        res_kind_next     = res_kind_reg;
        res_slot_next     = res_slot_reg;
        res_handler_next  = res_handler_reg;
        res_tag_next      = res_tag_reg;
        res_last_next     = res_last_reg;
        mem_we            = 1'b0;
        mem_wdata         = {quot_reg, handler_reg, tag_reg};

        if (!hold)
        begin
            if (uword.cond == COND_DISPATCH)
            begin
                pc_next = PC_IDLE;
                if (in_accept)
                begin
                    case (kind)
                        KIND_TICK: pc_next = PC_TICK_RD;
                        KIND_POST: pc_next = PC_POST_MUL1;
                        default:   pc_next = PC_IDLE;
                    endcase
                end
            end
            else if (cond_true)
            begin
                pc_next = uword.target;
            end
            else
            begin
                pc_next = upc_t'(pc_reg + 1'b1);
            end

            case (uword.act)
                ACT_DISPATCH:
                begin
                    if (in_accept)
                    begin
                        idx_next     = '0;
                        delay_next   = delay_ms;
                        handler_next = handler_id;
                        tag_next     = callback_tag;
                        if ((kind == KIND_CANCEL) && ({1'b0, slot_index} < (SLOT_W+1)'(USED)))
                        begin
                            valid_next[slot_index[IW-1:0]] = 1'b0;
                        end
                    end
                end
                ACT_TICK_SLOT:
                begin
                    if (slot_on)
                    begin
                        if (rd_count != '0)
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = {COUNT_W'(rd_count - 1'b1), rd_handler, rd_tag};
                        end
                        else
                        begin
                            valid_next[idx_reg] = 1'b0;
                            if (pend_valid_reg)
                            begin
                                out_valid_next   = 1'b1;
                                res_kind_next    = RES_FIRED;
                                res_slot_next    = SLOT_W'(pend_slot_reg);
                                res_handler_next = pend_handler_reg;
                                res_tag_next     = pend_tag_reg;
                                res_last_next    = 1'b0;
                            end
                            pend_valid_next   = 1'b1;
                            pend_slot_next    = idx_reg;
                            pend_handler_next = rd_handler;
                            pend_tag_next     = rd_tag;
                        end
                    end
                    if (!idx_last)
                    begin
                        idx_next = IW'(idx_reg + 1'b1);
                    end
                end
                ACT_FLUSH:
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next   = 1'b1;
                        res_kind_next    = RES_FIRED;
                        res_slot_next    = SLOT_W'(pend_slot_reg);
                        res_handler_next = pend_handler_reg;
                        res_tag_next     = pend_tag_reg;
                        res_last_next    = 1'b1;
                    end
                    pend_valid_next = 1'b0;
                end
                ACT_MUL1:
                begin
                    prod_next = PROD_W'(delay_reg) * TICKS_NUM;
                end
                ACT_MUL2:
                begin
                    quot_next = recip_prod[RECIP_SHIFT +: COUNT_W];
                end
                ACT_SEARCH:
                begin
                    if (cond_true)
                    begin
                        idx_next = IW'(idx_reg + 1'b1);
                    end
                end
                ACT_GRANT:
                begin
                    out_valid_next   = 1'b1;
                    res_handler_next = '0;
                    res_tag_next     = '0;
                    res_last_next    = 1'b1;
                    if (!slot_on)
                    begin
                        valid_next[idx_reg] = 1'b1;
                        mem_we              = 1'b1;
                        mem_wdata           = {quot_reg, handler_reg, tag_reg};
                        res_kind_next       = RES_GRANTED;
                        res_slot_next       = SLOT_W'(idx_reg);
                    end
                    else
                    begin
                        res_kind_next = RES_FULL;
                        res_slot_next = '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg           <= PC_IDLE;
            idx_reg          <= '0;
            valid_reg        <= '0;
            pend_valid_reg   <= 1'b0;
            pend_slot_reg    <= '0;
            pend_handler_reg <= '0;
            pend_tag_reg     <= '0;
            delay_reg        <= '0;
            handler_reg      <= '0;
            tag_reg          <= '0;
            prod_reg         <= '0;
            quot_reg         <= '0;
            out_valid_reg    <= 1'b0;
            res_kind_reg     <= RES_GRANTED;
            res_slot_reg     <= '0;
            res_handler_reg  <= '0;
            res_tag_reg      <= '0;
            res_last_reg     <= 1'b0;
        end
        else
        begin
            pc_reg           <= pc_next;
            idx_reg          <= idx_next;
            valid_reg        <= valid_next;
            pend_valid_reg   <= pend_valid_next;
            pend_slot_reg    <= pend_slot_next;
            pend_handler_reg <= pend_handler_next;
            pend_tag_reg     <= pend_tag_next;
            delay_reg        <= delay_next;
            handler_reg      <= handler_next;
            tag_reg          <= tag_next;
            prod_reg         <= prod_next;
            quot_reg         <= quot_next;
            out_valid_reg    <= out_valid_next;
            res_kind_reg     <= res_kind_next;
            res_slot_reg     <= res_slot_next;
            res_handler_reg  <= res_handler_next;
            res_tag_reg      <= res_tag_next;
            res_last_reg     <= res_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[idx_reg] <= mem_wdata;
        end
        rd_data_reg <= mem[rd_addr];
    end

endmodule

@@ rtl/tet_checker.sv @@
// Port-level checker for the timeout event table and its bind to the top level.
module tet_checker
    import tet_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_stall,
    input logic [KIND_W-1:0]    kind,
    input logic                 out_valid,
    input logic                 out_stall,
    input logic [KIND_W-1:0]    result_kind,
    input logic [SLOT_W-1:0]    slot_number,
    input logic [HANDLER_W-1:0] fired_handler,
    input logic [TAG_W-1:0]     fired_tag,
    input logic                 last_of_run
);

    // A stalled result word keeps its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(result_kind) && $stable(slot_number)
            && $stable(fired_handler) && $stable(fired_tag) && $stable(last_of_run))
        else $error("stalled result word changed");

    // After a cancel or an unused kind the input is free again in the following cycle.
    a_cancel_quick: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (kind != KIND_TICK) && (kind != KIND_POST) |=> !in_stall)
        else $error("cancel word did not finish in one cycle");

    // A post keeps the input busy through the multiply steps.
    a_post_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (kind == KIND_POST) |=> in_stall ##1 in_stall)
        else $error("post word released the input too early");

    // A post answer is always marked as the last word of its run.
    a_post_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_kind != RES_FIRED) |-> last_of_run)
        else $error("post answer not marked as the last word");

    // A refused post carries no slot, handler or tag.
    a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_kind == RES_FULL) |->
            (slot_number == '0) && (fired_handler == '0) && (fired_tag == '0))
        else $error("refused post carries payload");

endmodule

bind timeout_event_table_top tet_checker u_tet_checker (.*);
